// ----- rtl/core/nfca_pkg.sv -----
// Package for the next-fit chunk allocator: state and status codes, field widths.
// No dependencies; imported by next_fit_chunk_allocator_top.
package nfca_pkg;

  // Fixed field widths
  localparam int unsigned ReqW   = 32;
  localparam int unsigned CbW    = 17;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned LenW   = 9;
  localparam int unsigned DivCntW = 5;

  // Operation codes on func
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [CbW-1:0] CB_RESET = 17'd64;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FREED   = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SIZE,
    S_CAND,
    S_HEAD,
    S_SCAN,
    S_FREE_RD,
    S_FREE,
    S_DONE
  } state_e;

endpackage

// ----- rtl/core/next_fit_chunk_allocator_top.sv -----
// Next-fit chunk allocator: run-length table memory, size divider and search sequencer.
// Depends on nfca_pkg.
//
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   func_i, request_bytes_i, release_index_i
// out      out  out_valid_o / out_stall_i status, head_index, run_length, counts
// cfg      in   cfg_valid_i / cfg_ready_o cfg_chunk_bytes_i
//
// Allocate: a bit-serial divider turns bytes into chunks, a sizing step rounds up, then
// each visited candidate reads its head, then one entry per extra chunk (one table read per cycle),
// and the result goes to the output register. Free: a read-modify-write of the table memory.
// After reset a clearing pass zeroes the table; no item is taken.
// A stalled result waits in the output register while the next item is accepted.
module next_fit_chunk_allocator_top #(
  parameter int unsigned NUM_CHUNKS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nfca_pkg::CbW-1:0]    cfg_chunk_bytes_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [nfca_pkg::ReqW-1:0]   request_bytes_i,
  input  logic [nfca_pkg::IdxW-1:0]   release_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [nfca_pkg::IdxW-1:0]   head_index_o,
  output logic [nfca_pkg::LenW-1:0]   run_length_o,
  output logic [nfca_pkg::LenW-1:0]   chunks_in_use_o,
  output logic [nfca_pkg::LenW-1:0]   live_objects_o
);
  import nfca_pkg::*;

  localparam int unsigned AW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned LW = $clog2(NUM_CHUNKS + 1);
  localparam logic [LW-1:0] NumL    = LW'(NUM_CHUNKS);
  localparam logic [LW:0]   NumL1   = (LW+1)'(NUM_CHUNKS);
  localparam logic [AW-1:0] LastA   = AW'(NUM_CHUNKS - 1);
  localparam logic [32:0]   Num33   = 33'(NUM_CHUNKS);
  localparam logic [31:0]   Num32   = 32'(NUM_CHUNKS);

  // Table memory
  logic [LW-1:0] mem [NUM_CHUNKS];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [LW-1:0] mem_wd, rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  state_e state_q, state_d;
  logic [CbW-1:0]     cb_q, cb_d;
  logic [ReqW-1:0]    dq_q, dq_d;
  logic [CbW-1:0]     rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [LW-1:0]      need_q, need_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AW-1:0]      cur_q, cur_d, c_q, c_d, j_q, j_d, clr_q, clr_d;
  logic [LW-1:0]      i_q, i_d, used_q, used_d, obj_q, obj_d;
  status_e            rs_st_q, rs_st_d;
  logic [IdxW-1:0]    rs_head_q, rs_head_d;
  logic [LenW-1:0]    rs_len_q, rs_len_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_st_q, out_st_d;
  logic [IdxW-1:0]    out_head_q, out_head_d;
  logic [LenW-1:0]    out_len_q, out_len_d, out_used_q, out_used_d, out_obj_q, out_obj_d;

  // Combinational helpers
  logic [CbW-1:0]  divisor;
  logic [CbW:0]    trial;
  logic [32:0]     need33;
  logic [LW:0]     room, sum;
  logic [LW-1:0]   skip;
  logic [31:0]     c32, need32, idx32, used32, obj32;
  logic            load_out;

  assign divisor   = (cb_q == '0) ? CbW'(1) : cb_q;
  assign trial     = {rem_q, dq_q[ReqW-1]} - {1'b0, divisor};
  assign c32       = 32'(c_q);
  assign need32    = 32'(need_q);
  assign idx32     = 32'(idx_q);
  assign room      = NumL1 - (LW+1)'(c_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Next state, table access and bookkeeping
  always_comb begin
    state_d = state_q;
    cb_d = cb_q; dq_d = dq_q; rem_d = rem_q; cnt_d = cnt_q; need_d = need_q;
    idx_d = idx_q; cur_d = cur_q; c_d = c_q; j_d = j_q; clr_d = clr_q;
    i_d = i_q; used_d = used_q; obj_d = obj_q;
    rs_st_d = rs_st_q; rs_head_d = rs_head_q; rs_len_d = rs_len_q;
    mem_we = 1'b0; mem_wa = c_q; mem_wd = '0; mem_ra = c_q;
    need33 = '0; skip = '0; sum = '0;
    used32 = '0; obj32 = '0;
    load_out = 1'b0;

    if (cfg_valid_i) begin
      cb_d = cfg_chunk_bytes_i;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LastA) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = release_index_i;
          dq_d  = request_bytes_i;
          rem_d = '0;
          cnt_d = '0;
          state_d = (func_i == FN_FREE) ? S_FREE_RD : S_DIV;
        end
      end
      // One quotient bit per cycle
      S_DIV: begin
        if (!trial[CbW]) begin
          rem_d = trial[CbW-1:0];
          dq_d  = {dq_q[ReqW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[CbW-2:0], dq_q[ReqW-1]};
          dq_d  = {dq_q[ReqW-2:0], 1'b0};
        end
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == '1) state_d = S_SIZE;
      end
      // Round up, take one chunk minimum, reject oversize
      S_SIZE: begin
        need33 = {1'b0, dq_q} + 33'(rem_q != '0);
        if (need33 == '0) need33 = 33'd1;
        if (need33 > Num33) begin
          rs_st_d = ST_NOSPACE; rs_head_d = '0; rs_len_d = '0;
          state_d = S_DONE;
        end else begin
          need_d = need33[LW-1:0];
          c_d = cur_q;
          i_d = '0;
          state_d = S_CAND;
        end
      end
      S_CAND: begin
        if (i_q == NumL) begin
          rs_st_d = ST_NOSPACE; rs_head_d = '0; rs_len_d = '0;
          state_d = S_DONE;
        end else begin
          mem_ra = c_q;
          state_d = S_HEAD;
        end
      end
      // Head entry is in rd_q
      S_HEAD: begin
        if (room >= {1'b0, need_q} && rd_q == '0) begin
          if (need_q == LW'(1)) begin
            mem_we = 1'b1; mem_wa = c_q; mem_wd = need_q;
            cur_d = c_q; used_d = used_q + need_q; obj_d = obj_q + LW'(1);
            rs_st_d = ST_ALLOC; rs_head_d = c32[IdxW-1:0]; rs_len_d = need32[LenW-1:0];
            state_d = S_DONE;
          end else begin
            j_d = AW'(1);
            mem_ra = c_q + AW'(1);
            state_d = S_SCAN;
          end
        end else begin
          skip = (rd_q == '0) ? LW'(1) : rd_q;
          sum  = (LW+1)'(c_q) + (LW+1)'(skip);
          if (sum >= NumL1) sum = sum - NumL1;
          c_d = sum[AW-1:0];
          i_d = i_q + LW'(1);
          state_d = S_CAND;
        end
      end
      // Entry c+j is in rd_q
      S_SCAN: begin
        if (rd_q != '0) begin
          sum = (LW+1)'(c_q) + (LW+1)'(1);
          if (sum >= NumL1) sum = sum - NumL1;
          c_d = sum[AW-1:0];
          i_d = i_q + LW'(1);
          state_d = S_CAND;
        end else if ((LW'(j_q) + LW'(1)) == need_q) begin
          mem_we = 1'b1; mem_wa = c_q; mem_wd = need_q;
          cur_d = c_q; used_d = used_q + need_q; obj_d = obj_q + LW'(1);
          rs_st_d = ST_ALLOC; rs_head_d = c32[IdxW-1:0]; rs_len_d = need32[LenW-1:0];
          state_d = S_DONE;
        end else begin
          j_d = j_q + AW'(1);
          mem_ra = c_q + j_q + AW'(1);
        end
      end
      S_FREE_RD: begin
        if (idx32 >= Num32) begin
          rs_st_d = ST_BADFREE; rs_head_d = idx_q; rs_len_d = '0;
          state_d = S_DONE;
        end else begin
          mem_ra = idx32[AW-1:0];
          state_d = S_FREE;
        end
      end
      // Release the head's run
      S_FREE: begin
        if (rd_q == '0) begin
          rs_st_d = ST_BADFREE; rs_head_d = idx_q; rs_len_d = '0;
        end else begin
          mem_we = 1'b1; mem_wa = idx32[AW-1:0]; mem_wd = '0;
          used_d = (used_q >= rd_q) ? used_q - rd_q : '0;
          obj_d  = (obj_q != '0) ? obj_q - LW'(1) : '0;
          used32 = 32'(rd_q);
          rs_st_d = ST_FREED; rs_head_d = idx_q; rs_len_d = used32[LenW-1:0];
        end
        state_d = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    used32 = 32'(used_q);
    obj32  = 32'(obj_q);
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d = out_st_q; out_head_d = out_head_q; out_len_d = out_len_q;
    out_used_d = out_used_q; out_obj_d = out_obj_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_st_d = rs_st_q; out_head_d = rs_head_q; out_len_d = rs_len_q;
      out_used_d = used32[LenW-1:0]; out_obj_d = obj32[LenW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cb_q <= CB_RESET;
      cur_q <= '0;
      used_q <= '0;
      obj_q <= '0;
      clr_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cb_q <= cb_d;
      cur_q <= cur_d;
      used_q <= used_d;
      obj_q <= obj_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dq_q <= dq_d; rem_q <= rem_d; need_q <= need_d; idx_q <= idx_d;
    c_q <= c_d; j_q <= j_d; i_q <= i_d;
    rs_st_q <= rs_st_d; rs_head_q <= rs_head_d; rs_len_q <= rs_len_d;
    out_st_q <= out_st_d; out_head_q <= out_head_d; out_len_q <= out_len_d;
    out_used_q <= out_used_d; out_obj_q <= out_obj_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign head_index_o    = out_head_q;
  assign run_length_o    = out_len_q;
  assign chunks_in_use_o = out_used_q;
  assign live_objects_o  = out_obj_q;

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NumL) else $error("chunks in use exceed pool");
  a_obj_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obj_q <= used_q) else $error("more objects than used chunks");
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o) else $error("item taken during clearing");
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

endmodule

// ----- tb/tb_next_fit_chunk_allocator_top.sv -----
// Testbench for next_fit_chunk_allocator_top: directed table, then random alloc/free traffic
// under several chunk sizes, checked against a built-in next-fit pool predictor.
// Depends on nfca_pkg and next_fit_chunk_allocator_top.
`timescale 1ns / 1ps

module tb_next_fit_chunk_allocator_top;
  import nfca_pkg::*;

  localparam int unsigned NumChunks = 256;
  localparam int unsigned IdleLimit = 400000;
  localparam int unsigned RandItemsPerPhase = 300;

  typedef struct packed {
    status_e             status;
    logic [IdxW-1:0]     head;
    logic [LenW-1:0]     len;
    logic [LenW-1:0]     used;
    logic [LenW-1:0]     objs;
  } alloc_result_t;

  typedef struct {
    logic            func;
    logic [ReqW-1:0] req;
    logic [IdxW-1:0] idx;
    bit              typed;
    alloc_result_t   res;
  } stim_row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CbW-1:0] cfg_cb;
  logic in_valid, in_stall, func;
  logic [ReqW-1:0] req_bytes;
  logic [IdxW-1:0] rel_idx;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [IdxW-1:0] head_index;
  logic [LenW-1:0] run_length, chunks_in_use, live_objects;

  // Pool model state
  logic [LenW-1:0] pool_runs [NumChunks];
  logic [IdxW-1:0] pool_cursor;
  logic [LenW-1:0] pool_used, pool_objs;
  logic [CbW-1:0]  pool_cb;

  alloc_result_t pending_results [$];
  int unsigned errors, items_taken, idle_cycles;
  bit calm;

  next_fit_chunk_allocator_top #(.NUM_CHUNKS(NumChunks)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_chunk_bytes_i(cfg_cb),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .request_bytes_i(req_bytes), .release_index_i(rel_idx),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .head_index_o(head_index), .run_length_o(run_length),
    .chunks_in_use_o(chunks_in_use), .live_objects_o(live_objects)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Apply one operation to the pool model and return its result
  function automatic alloc_result_t pool_apply(logic f, logic [ReqW-1:0] req,
                                               logic [IdxW-1:0] idx);
    alloc_result_t r;
    longint unsigned cb, need;
    int unsigned c, skip;
    bit fits;
    r = '{status: ST_NOSPACE, head: '0, len: '0, used: '0, objs: '0};
    if (f == FN_ALLOC) begin
      cb = (pool_cb == 0) ? 1 : pool_cb;
      need = (longint'(req) + cb - 1) / cb;
      if (need == 0) need = 1;
      if (need <= NumChunks) begin
        c = pool_cursor;
        for (int i = 0; i < NumChunks; i++) begin
          fits = (NumChunks - c >= need);
          for (int j = 0; fits && j < need; j++)
            if (pool_runs[c + j] != 0) fits = 0;
          if (fits) begin
            pool_cursor = IdxW'(c);
            pool_runs[c] = LenW'(need);
            pool_used = pool_used + LenW'(need);
            pool_objs = pool_objs + LenW'(1);
            r.status = ST_ALLOC;
            r.head = IdxW'(c);
            r.len = LenW'(need);
            break;
          end
          skip = (pool_runs[c] != 0) ? pool_runs[c] : 1;
          c = (c + skip) % NumChunks;
        end
      end
    end else if (pool_runs[idx] == 0) begin
      r.status = ST_BADFREE;
      r.head = idx;
    end else begin
      r.status = ST_FREED;
      r.head = idx;
      r.len = pool_runs[idx];
      pool_runs[idx] = '0;
      pool_used = (pool_used >= r.len) ? pool_used - r.len : '0;
      pool_objs = (pool_objs != 0) ? pool_objs - LenW'(1) : '0;
    end
    r.used = pool_used;
    r.objs = pool_objs;
    return r;
  endfunction

  // Offer one item, hold it until taken, then queue its expected result
  task automatic send_item(logic f, logic [ReqW-1:0] req, logic [IdxW-1:0] idx,
                           bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    in_valid <= 1'b1;
    func <= f;
    req_bytes <= req;
    rel_idx <= idx;
    do @(posedge clk); while (in_stall);
    r = pool_apply(f, req, idx);
    pending_results.push_back(typed ? typed_res : r);
    items_taken++;
  endtask

  task automatic idle_gap();
    int unsigned g;
    g = 0;
    if (!calm && $urandom_range(0, 9) >= 7)
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write chunk_bytes
  task automatic write_chunk_bytes(logic [CbW-1:0] v);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_cb <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_cb = v;
  endtask

  task automatic random_item();
    logic [IdxW-1:0] heads [$];
    longint unsigned n, cb, req;
    logic [IdxW-1:0] idx;
    idx = IdxW'($urandom);
    n = 0;
    req = 0;
    for (int i = 0; i < NumChunks; i++)
      if (pool_runs[i] != 0) heads.push_back(IdxW'(i));
    if (heads.size() > 0 && ($urandom_range(0, 99) < 40 || pool_used > 200)) begin
      if ($urandom_range(0, 99) >= 15) idx = heads[$urandom_range(0, heads.size() - 1)];
      send_item(FN_FREE, $urandom, idx, 0, '0);
    end else begin
      cb = (pool_cb == 0) ? 1 : pool_cb;
      case ($urandom_range(0, 19))
        0, 1: req = $urandom;
        2: req = 0;
        3: n = $urandom_range(1, 64);
        4: n = $urandom_range(200, 257);
        default: n = $urandom_range(1, 8);
      endcase
      // Shape a byte count that rounds to n chunks
      if (n != 0 && $urandom_range(0, 19) > 2) begin
        req = (n - 1) * cb + 1 + $urandom_range(0, cb - 1);
        if (req > 64'hFFFF_FFFF) req = 64'hFFFF_FFFF;
      end
      send_item(FN_ALLOC, req[ReqW-1:0], idx, 0, '0);
    end
  endtask

  // Stimulus: directed table, then random phases under several chunk sizes
  initial begin
    stim_row_t rows [$];
    logic [CbW-1:0] sizes [5];
    sizes = '{17'd1, 17'd65536, 17'd3, 17'd64, 17'd0};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_cb = '0;
    in_valid = 1'b0;
    func = FN_ALLOC;
    req_bytes = '0;
    rel_idx = '0;
    errors = 0;
    items_taken = 0;
    calm = 0;
    for (int i = 0; i < NumChunks; i++) pool_runs[i] = '0;
    pool_cursor = '0;
    pool_used = '0;
    pool_objs = '0;
    pool_cb = CB_RESET;
    rows = '{
      '{FN_ALLOC, 32'd0, 8'hFF, 1, '{ST_ALLOC, 8'd0, 9'd1, 9'd1, 9'd1}},
      '{FN_ALLOC, 32'd64, 8'd0, 1, '{ST_ALLOC, 8'd1, 9'd1, 9'd2, 9'd2}},
      '{FN_ALLOC, 32'd65, 8'd0, 1, '{ST_ALLOC, 8'd2, 9'd2, 9'd4, 9'd3}},
      '{FN_ALLOC, 32'hFFFF_FFFF, 8'd0, 1, '{ST_NOSPACE, 8'd0, 9'd0, 9'd4, 9'd3}},
      '{FN_ALLOC, 32'd16385, 8'd0, 1, '{ST_NOSPACE, 8'd0, 9'd0, 9'd4, 9'd3}},
      '{FN_FREE, 32'hFFFF_FFFF, 8'd1, 1, '{ST_FREED, 8'd1, 9'd1, 9'd3, 9'd2}},
      '{FN_FREE, 32'd0, 8'd1, 1, '{ST_BADFREE, 8'd1, 9'd0, 9'd3, 9'd2}},
      '{FN_FREE, 32'd0, 8'd3, 1, '{ST_BADFREE, 8'd3, 9'd0, 9'd3, 9'd2}},
      '{FN_FREE, 32'd0, 8'd255, 1, '{ST_BADFREE, 8'd255, 9'd0, 9'd3, 9'd2}},
      '{FN_ALLOC, 32'd16384, 8'd0, 1, '{ST_NOSPACE, 8'd0, 9'd0, 9'd3, 9'd2}},
      '{FN_ALLOC, 32'd1, 8'd0, 0, '0},
      '{FN_ALLOC, 32'd200, 8'd0, 0, '0},
      '{FN_FREE, 32'd0, 8'd0, 0, '0},
      '{FN_FREE, 32'd0, 8'd2, 0, '0},
      '{FN_FREE, 32'd0, 8'd4, 0, '0},
      '{FN_FREE, 32'd0, 8'd5, 0, '0},
      '{FN_ALLOC, 32'd16384, 8'd0, 0, '0},
      '{FN_ALLOC, 32'd0, 8'd0, 1, '{ST_NOSPACE, 8'd0, 9'd0, 9'd256, 9'd1}},
      '{FN_FREE, 32'd0, 8'd0, 1, '{ST_FREED, 8'd0, 9'd256, 9'd0, 9'd0}},
      '{FN_ALLOC, 32'hAAAA_5555, 8'h55, 0, '0},
      '{FN_ALLOC, 32'd130, 8'hAA, 0, '0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      send_item(rows[i].func, rows[i].req, rows[i].idx, rows[i].typed, rows[i].res);
      idle_gap();
    end
    foreach (sizes[p]) begin
      write_chunk_bytes(sizes[p]);
      for (int k = 0; k < RandItemsPerPhase; k++) begin
        if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
        idle_gap();
      end
    end
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Receiver stall: random, one long hold to back the block up, rare long bursts
  initial begin
    bit long_done;
    long_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_done && items_taken >= 300) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_done = 1;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 199) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{status_e'(status), head_index, run_length, chunks_in_use, live_objects};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
